// ===== design/srtf_pkg.sv =====
// Shared types, constants and helpers for the shortest-remaining-time scheduler.
// Used by srtf_ctrl, srtf_dp and shortest_remaining_time_scheduler. No dependencies.
package srtf_pkg;

    localparam int JOB_SLOTS_DEF = 16;

    localparam int TAG_W   = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int CNT16_W = 16;
    localparam int SUM_W   = 48;
    localparam int STAT_W  = 3;

    // s_tdata: job_tag, burst_length (24 bits, 3 bytes)
    localparam int S_DATA_W = 24;
    // m_tdata: done_tag, turnaround, waiting, completed_count,
    //          waiting_sum, turnaround_sum, now (216 bits, 27 bytes)
    localparam int M_DATA_W = 216;

    // Input kind codes
    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_ZERO      = 3'd2,
        ST_IDLE      = 3'd3,
        ST_RAN       = 3'd4,
        ST_COMPLETED = 3'd5
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture transaction, start scan
        logic scan;      // compare one slot against the current best
        logic update;    // run the best job one unit
        logic accum;     // form the waiting time
        logic finish;    // arrival write / totals, load output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic in_tick;   // incoming transaction is a tick
        logic scan_done; // every valid slot has been compared
        logic out_free;  // output register can take a result
    } dp_stat_t;

    // 48-bit saturating accumulate of a 32-bit value
    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W - TIME_W + 1){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== design/srtf_ctrl.sv =====
// Controller state machine for the scheduler: sequences load, scan, update, accumulate and finish.
// Depends on srtf_pkg (dp_cmd_t, dp_stat_t).
module srtf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  srtf_pkg::dp_stat_t stat,
    output srtf_pkg::dp_cmd_t  cmd
);
    import srtf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_ACCUM  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.in_tick ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (stat.scan_done) begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: state_next = S_ACCUM;
            S_ACCUM:  state_next = S_FINISH;
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode
    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.scan   = (state_reg == S_SCAN) && !stat.scan_done;
    assign cmd.update = (state_reg == S_UPDATE);
    assign cmd.accum  = (state_reg == S_ACCUM);
    assign cmd.finish = (state_reg == S_FINISH) && stat.out_free;

`ifndef ASSERT_OFF
    // A result held off by a full output register keeps the controller waiting
    a_finish_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && !stat.out_free) |=> (state_reg == S_FINISH))
        else $error("finish left while output register busy");
`endif

endmodule

// ===== design/srtf_dp.sv =====
// Datapath for the scheduler: job slot table, sequential min scan, timers,
// saturating totals and the output register. Depends on srtf_pkg.
module srtf_dp #(
    parameter int JOB_SLOTS = srtf_pkg::JOB_SLOTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [srtf_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srtf_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [srtf_pkg::STAT_W-1:0]     m_tuser,
    input  srtf_pkg::dp_cmd_t               cmd,
    output srtf_pkg::dp_stat_t              stat
);
    import srtf_pkg::*;

    localparam int IDX_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int CNT_W = $clog2(JOB_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(JOB_SLOTS);

    // Slot table, kept in arrival order, valid entries below count_reg
    logic [BURST_W-1:0] slot_rem   [JOB_SLOTS];
    logic [BURST_W-1:0] slot_burst [JOB_SLOTS];
    logic [TIME_W-1:0]  slot_arr   [JOB_SLOTS];
    logic [TAG_W-1:0]   slot_tag   [JOB_SLOTS];

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [BURST_W-1:0] best_rem_reg;
    logic [BURST_W-1:0] best_burst_reg;
    logic [TIME_W-1:0]  best_arr_reg;
    logic [TAG_W-1:0]   best_tag_reg;

    logic               tick_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [BURST_W-1:0] burst_reg;

    logic [TIME_W-1:0]  time_reg;
    logic [SUM_W-1:0]   wsum_reg;
    logic [SUM_W-1:0]   tsum_reg;
    logic [CNT16_W-1:0] done_reg;

    status_t            upd_status_reg;
    logic [TIME_W-1:0]  turn_reg;
    logic [TIME_W-1:0]  wait_reg;

    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [STAT_W-1:0]  m_user_reg;

    logic [IDX_W-1:0]   rd_idx;
    logic               better;
    logic               empty;
    logic               full;
    logic               completes;
    logic               arrive_ok;
    status_t            fin_status;
    logic [TAG_W-1:0]   fin_tag;

    // Status toward the controller
    assign stat.in_tick   = (s_tuser == KIND_TICK);
    assign stat.scan_done = (scan_reg >= count_reg);
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= SLOTS_C);
    assign completes = !empty && (best_rem_reg == BURST_W'(1));
    assign arrive_ok = (tick_reg == KIND_ARRIVE) && (burst_reg != '0) && !full;

    // One slot compared per scan cycle; strict less keeps the earlier arrival on ties
    assign rd_idx = stat.scan_done ? '0 : scan_reg[IDX_W-1:0];
    assign better = slot_rem[rd_idx] < best_rem_reg;

    // Slot table writes: arrival append, decrement, or remove with shift down
    always_ff @(posedge aclk) begin
        if (cmd.finish && arrive_ok) begin
            slot_rem[count_reg[IDX_W-1:0]]   <= burst_reg;
            slot_burst[count_reg[IDX_W-1:0]] <= burst_reg;
            slot_arr[count_reg[IDX_W-1:0]]   <= time_reg;
            slot_tag[count_reg[IDX_W-1:0]]   <= tag_reg;
        end else if (cmd.update && !empty) begin
            if (completes) begin
                for (int j = 0; j < JOB_SLOTS - 1; j++) begin
                    if (IDX_W'(j) >= best_idx_reg) begin
                        slot_rem[j]   <= slot_rem[j+1];
                        slot_burst[j] <= slot_burst[j+1];
                        slot_arr[j]   <= slot_arr[j+1];
                        slot_tag[j]   <= slot_tag[j+1];
                    end
                end
            end else begin
                slot_rem[best_idx_reg] <= best_rem_reg - BURST_W'(1);
            end
        end
    end

    // Occupancy count
    always_comb begin
        count_next = count_reg;
        if (cmd.finish && arrive_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.update && completes) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control state: count, time, totals, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            time_reg    <= '0;
            wsum_reg    <= '0;
            tsum_reg    <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load && stat.in_tick) begin
                time_reg <= time_reg + TIME_W'(1);
            end
            if (cmd.finish && tick_reg == KIND_TICK) begin
                wsum_reg <= sat_add48(wsum_reg, wait_reg);
                tsum_reg <= sat_add48(tsum_reg, turn_reg);
                if (upd_status_reg == ST_COMPLETED && done_reg != '1) begin
                    done_reg <= done_reg + CNT16_W'(1);
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction capture and scan
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tick_reg       <= s_tuser;
            tag_reg        <= s_tdata[TAG_W-1:0];
            burst_reg      <= s_tdata[TAG_W +: BURST_W];
            scan_reg       <= CNT_W'(1);
            best_idx_reg   <= '0;
            best_rem_reg   <= slot_rem[0];
            best_burst_reg <= slot_burst[0];
            best_arr_reg   <= slot_arr[0];
            best_tag_reg   <= slot_tag[0];
        end else if (cmd.scan) begin
            scan_reg <= scan_reg + CNT_W'(1);
            if (better) begin
                best_idx_reg   <= rd_idx;
                best_rem_reg   <= slot_rem[rd_idx];
                best_burst_reg <= slot_burst[rd_idx];
                best_arr_reg   <= slot_arr[rd_idx];
                best_tag_reg   <= slot_tag[rd_idx];
            end
        end
    end

    // Run step: status and turnaround, then waiting time
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            if (empty) begin
                upd_status_reg <= ST_IDLE;
            end else if (completes) begin
                upd_status_reg <= ST_COMPLETED;
            end else begin
                upd_status_reg <= ST_RAN;
            end
            turn_reg <= completes ? (time_reg - best_arr_reg) : '0;
        end
        if (cmd.accum) begin
            wait_reg <= (upd_status_reg == ST_COMPLETED)
                      ? (turn_reg - {{(TIME_W - BURST_W){1'b0}}, best_burst_reg}) : '0;
        end
    end

    // Result status and tag
    always_comb begin
        if (tick_reg == KIND_TICK) begin
            fin_status = upd_status_reg;
        end else if (burst_reg == '0) begin
            fin_status = ST_ZERO;
        end else if (full) begin
            fin_status = ST_FULL;
        end else begin
            fin_status = ST_ACCEPTED;
        end
        fin_tag = (fin_status == ST_RAN || fin_status == ST_COMPLETED) ? best_tag_reg : '0;
    end

    // Output register; totals shown after this transaction
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_user_reg <= fin_status;
            m_data_reg <= {time_reg,
                           (tick_reg == KIND_TICK) ? sat_add48(tsum_reg, turn_reg) : tsum_reg,
                           (tick_reg == KIND_TICK) ? sat_add48(wsum_reg, wait_reg) : wsum_reg,
                           (upd_status_reg == ST_COMPLETED && tick_reg == KIND_TICK
                            && done_reg != '1) ? done_reg + CNT16_W'(1) : done_reg,
                           (tick_reg == KIND_TICK) ? wait_reg : TIME_W'(0),
                           (tick_reg == KIND_TICK) ? turn_reg : TIME_W'(0),
                           fin_tag};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SLOTS_C)
        else $error("slot count beyond table size");
    a_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && completes) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("completed job not removed");
    a_append: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.finish && arrive_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted job not appended");
`endif

endmodule

// ===== design/shortest_remaining_time_scheduler.sv =====
// Flow: an arrival goes from IDLE straight to FINISH, which loads the output register;
// a tick runs the one-slot-per-cycle min scan over the jobs held, then UPDATE, ACCUM, FINISH.
// One transaction in work at a time: the next is taken only back in IDLE, and it is
// accepted while the result waits in the output reg.
// Reset (aresetn, synchronous): empties the table, clears time and totals;
// slot contents are undefined until written, no clearing pass.
module shortest_remaining_time_scheduler #(
    parameter int JOB_SLOTS = srtf_pkg::JOB_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srtf_pkg::S_DATA_W-1:0] s_tdata,  // job_tag, burst_length
    input  logic                          s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // done_tag, turnaround, waiting, completed_count, waiting_sum, turnaround_sum, now
    output logic [srtf_pkg::M_DATA_W-1:0] m_tdata,
    output logic [srtf_pkg::STAT_W-1:0]   m_tuser   // status
);
    import srtf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    srtf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srtf_dp #(
        .JOB_SLOTS (JOB_SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== test/tb_shortest_remaining_time_scheduler.sv =====
// Self-checking testbench for the SRTF job scheduler: directed table, then random
// arrival/tick traffic and a final drain, checked against an in-bench scheduler model or hand-typed rows.
// Depends on srtf_pkg and shortest_remaining_time_scheduler.
`timescale 1ns / 100ps

module tb_shortest_remaining_time_scheduler;
    import srtf_pkg::*;

    localparam int SLOTS        = JOB_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 1290;
    localparam int DRAIN_ITEMS  = 32;    // ticks sent after the random part
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int STALL_LIMIT  = 5000;  // cycles with no transaction on either side
    localparam int SETTLE       = 32;    // idle cycles after the last result before finishing

    // How much of a directed row's result is typed in by hand
    typedef enum logic [1:0] {
        PIN_NONE,
        PIN_STATUS,
        PIN_ALL
    } pin_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tag;
        logic [15:0] burst;
    } job_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  done_tag;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [15:0] done_count;
        logic [47:0] wait_sum;
        logic [47:0] turn_sum;
        logic [31:0] now;
    } sched_result_t;

    // PIN_ALL rows: every result field is zero except status and now
    typedef struct packed {
        logic        kind;
        logic [7:0]  tag;
        logic [15:0] burst;
        logic [7:0]  reps;
        pin_t        pin;
        status_t     status;
        logic [31:0] now;
    } dir_row_t;

    localparam int DIR_ROWS = 12;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{KIND_TICK,   8'h00, 16'h0000, 8'd1,  PIN_ALL,    ST_IDLE,      32'd1}, // empty table
        '{KIND_ARRIVE, 8'h00, 16'h0000, 8'd1,  PIN_ALL,    ST_ZERO,      32'd1},
        '{KIND_ARRIVE, 8'hA5, 16'hFFFF, 8'd1,  PIN_ALL,    ST_ACCEPTED,  32'd1}, // longest job
        '{KIND_ARRIVE, 8'h00, 16'h0001, 8'd1,  PIN_STATUS, ST_ACCEPTED,  32'd0},
        '{KIND_TICK,   8'h00, 16'h0000, 8'd1,  PIN_STATUS, ST_COMPLETED, 32'd0},
        '{KIND_ARRIVE, 8'h11, 16'h0003, 8'd1,  PIN_NONE,   ST_ACCEPTED,  32'd0},
        '{KIND_ARRIVE, 8'h22, 16'h0003, 8'd1,  PIN_NONE,   ST_ACCEPTED,  32'd0}, // tie
        '{KIND_TICK,   8'h00, 16'h0000, 8'd3,  PIN_NONE,   ST_RAN,       32'd0},
        '{KIND_ARRIVE, 8'h5A, 16'h0002, 8'd14, PIN_STATUS, ST_ACCEPTED,  32'd0}, // fill up
        '{KIND_ARRIVE, 8'hFF, 16'hFFFF, 8'd1,  PIN_STATUS, ST_FULL,      32'd0},
        '{KIND_ARRIVE, 8'hFF, 16'h0000, 8'd1,  PIN_STATUS, ST_ZERO,      32'd0}, // zero wins
        '{KIND_TICK,   8'hFF, 16'hFFFF, 8'd2,  PIN_NONE,   ST_RAN,       32'd0}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // job_tag, burst_length
    logic                s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    // done_tag, turnaround, waiting, completed_count, waiting_sum, turnaround_sum, now
    logic [M_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]   m_tuser;   // status

    // Scheduler model state: slots 0..jobs_held-1 hold jobs in arrival order
    logic [15:0] job_left    [SLOTS];
    logic [15:0] job_burst   [SLOTS];
    logic [31:0] job_arrival [SLOTS];
    logic [7:0]  job_tags    [SLOTS];
    int          jobs_held  = 0;
    logic [31:0] clock_now  = '0;
    logic [47:0] wait_acc   = '0;
    logic [47:0] turn_acc   = '0;
    logic [15:0] done_count = '0;

    sched_result_t sched_expect [$];
    int            mismatches   = 0;
    int            burst_left   = 0;
    int            stall_cycles = 0;
    bit            hold_request = 1'b0;

    shortest_remaining_time_scheduler #(
        .JOB_SLOTS(SLOTS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [47:0] accumulate_capped(input logic [47:0] acc,
                                                      input logic [31:0] inc);
        logic [48:0] sum;
        sum = {1'b0, acc} + {17'd0, inc};
        return sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
    endfunction

    // Apply one transaction to the model and return the result it must produce
    function automatic sched_result_t schedule_step(input job_item_t it);
        sched_result_t r;
        int            best;
        logic [31:0]   turn;
        r = '0;
        if (it.kind == KIND_ARRIVE) begin
            if (it.burst == 16'd0) begin
                r.status = ST_ZERO;
            end else if (jobs_held == SLOTS) begin
                r.status = ST_FULL;
            end else begin
                job_left[jobs_held]    = it.burst;
                job_burst[jobs_held]   = it.burst;
                job_arrival[jobs_held] = clock_now;
                job_tags[jobs_held]    = it.tag;
                jobs_held++;
                r.status = ST_ACCEPTED;
            end
        end else begin
            clock_now = clock_now + 32'd1;
            if (jobs_held == 0) begin
                r.status = ST_IDLE;
            end else begin
                // least remaining time; strict compare keeps the earlier arrival on a tie
                best = 0;
                for (int i = 1; i < jobs_held; i++)
                    if (job_left[i] < job_left[best])
                        best = i;
                r.done_tag = job_tags[best];
                job_left[best] = job_left[best] - 16'd1;
                if (job_left[best] == 16'd0) begin
                    turn         = clock_now - job_arrival[best];
                    r.turnaround = turn;
                    r.waiting    = turn - {16'd0, job_burst[best]};
                    wait_acc     = accumulate_capped(wait_acc, r.waiting);
                    turn_acc     = accumulate_capped(turn_acc, turn);
                    if (done_count != 16'hFFFF)
                        done_count++;
                    for (int i = best; i < jobs_held - 1; i++) begin
                        job_left[i]    = job_left[i + 1];
                        job_burst[i]   = job_burst[i + 1];
                        job_arrival[i] = job_arrival[i + 1];
                        job_tags[i]    = job_tags[i + 1];
                    end
                    jobs_held--;
                    r.status = ST_COMPLETED;
                end else begin
                    r.status = ST_RAN;
                end
            end
        end
        r.done_count = done_count;
        r.wait_sum   = wait_acc;
        r.turn_sum   = turn_acc;
        r.now        = clock_now;
        return r;
    endfunction

    // Offer one transaction in sender bursts with random gaps, then log its result
    task automatic send_item(input job_item_t it, input pin_t pin, input status_t st,
                             input logic [31:0] pin_now);
        int            gap;
        sched_result_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.burst, it.tag};
        do @(posedge aclk); while (!s_tready);
        r = schedule_step(it);
        if (pin == PIN_STATUS) begin
            r.status = st;
        end else if (pin == PIN_ALL) begin
            r        = '0;
            r.status = st;
            r.now    = pin_now;
        end
        sched_expect.insert(sched_expect.size(), r);
    endtask

    // Stimulus: reset, directed table, random traffic, short drain of ticks
    initial begin
        job_item_t it;
        int        arrive_pct;
        int        roll;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_ARRIVE;
        s_tdata  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            it = '{DIR_TABLE[i].kind, DIR_TABLE[i].tag, DIR_TABLE[i].burst};
            for (int k = 0; k < DIR_TABLE[i].reps; k++)
                send_item(it, DIR_TABLE[i].pin, DIR_TABLE[i].status, DIR_TABLE[i].now);
        end

        arrive_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // arrival mix changes every hundred items so the table fills and empties
            if (n % 100 == 0)
                arrive_pct = 20 + 25 * $urandom_range(2);
            if (n == 600)
                hold_request = 1'b1;
            it.kind = ($urandom_range(99) < arrive_pct) ? KIND_ARRIVE : KIND_TICK;
            it.tag  = 8'($urandom_range(255));
            roll    = $urandom_range(99);
            if (roll < 4)
                it.burst = 16'd0;
            else if (roll < 70)
                it.burst = 16'($urandom_range(1, 8));
            else if (roll < 97)
                it.burst = 16'($urandom_range(1, 64));
            else
                it.burst = 16'($urandom_range(1, 1000));
            send_item(it, PIN_NONE, ST_ACCEPTED, 32'd0);
        end

        // a short run of ticks retires the shorter jobs left in the table
        for (int d = 0; d < DRAIN_ITEMS && jobs_held != 0; d++) begin
            it = '{KIND_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535))};
            send_item(it, PIN_NONE, ST_ACCEPTED, 32'd0);
        end

        s_tvalid <= 1'b0;
        while (sched_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: stall pattern of its own, plus one long hold-off on request
    initial begin
        rx_mode_t   mode;
        int         span;
        logic [1:0] phase;
        mode  = RX_OPEN;
        span  = 0;
        phase = '0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (int h = 1; h < HOLD_CYCLES; h++) @(posedge aclk);
            end else begin
                if (span == 0) begin
                    mode = rx_mode_t'($urandom_range(2));
                    span = $urandom_range(16, 96);
                end
                span--;
                phase = phase + 2'd1;
                case (mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= ($urandom_range(99) < 60);
                    default:    m_tready <= (phase != 2'b11);
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input logic [47:0] want,
                                        input logic [47:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t: %s expected %0h, got %0h", $realtime, name, want, got);
        end
    endfunction

    // Result monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = status_t'(m_tuser);
            got.done_tag   = m_tdata[7:0];
            got.turnaround = m_tdata[39:8];
            got.waiting    = m_tdata[71:40];
            got.done_count = m_tdata[87:72];
            got.wait_sum   = m_tdata[135:88];
            got.turn_sum   = m_tdata[183:136];
            got.now        = m_tdata[215:184];
            if (sched_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result transaction with nothing expected, status %0d",
                             $realtime, m_tuser);
            end else begin
                want = sched_expect.pop_front();
                check_field("status", 48'(want.status), 48'(m_tuser));
                check_field("done_tag", 48'(want.done_tag), 48'(got.done_tag));
                check_field("turnaround", 48'(want.turnaround), 48'(got.turnaround));
                check_field("waiting", 48'(want.waiting), 48'(got.waiting));
                check_field("completed_count", 48'(want.done_count), 48'(got.done_count));
                check_field("waiting_sum", want.wait_sum, got.wait_sum);
                check_field("turnaround_sum", want.turn_sum, got.turn_sum);
                check_field("now", 48'(want.now), 48'(got.now));
            end
        end
    end

    // Watchdog: too long without any transaction means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
design/srtf_pkg.sv
design/srtf_ctrl.sv
design/srtf_dp.sv
design/shortest_remaining_time_scheduler.sv
test/tb_shortest_remaining_time_scheduler.sv
